/* sv/bmpd_pkg.sv */
// ---------------------------------------------------------------------------
// bmpd_pkg: shared types and constants of the BMP pixel stream decoder
// Mode and register codes, reset values, and the structs that pass between
// the decode front end, the issue sequencer and the palette memory.
// ---------------------------------------------------------------------------
package bmpd_pkg;

  // pixel_mode codes
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_16BPP = 3'd3;
  localparam logic [2:0] MODE_24BPP = 3'd4;
  localparam logic [2:0] MODE_32BPP = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [1:0] REG_FILL_MASK    = 2'd3;

  // reset values
  localparam logic [2:0]  RST_PIXEL_MODE = MODE_8BPP;
  localparam logic [12:0] RST_DIM        = 13'd1;
  localparam logic [15:0] RST_FILL_MASK  = 16'h8000;

  // palette load length in bytes (4 per entry)
  localparam logic [10:0] LOAD_BYTES_1BPP = 11'd8;
  localparam logic [10:0] LOAD_BYTES_4BPP = 11'd64;
  localparam logic [10:0] LOAD_BYTES_8BPP = 11'd1024;

  // one accepted byte's worth of pixels, waiting to be issued
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;   // direct pixel, or the index byte in 7:0
    logic [2:0]  cnt;     // pixel count minus one
    logic [11:0] col;
    logic [11:0] row;
    logic        done;
  } job_t;

  // one pixel on its way through the palette read stage
  typedef struct packed {
    logic        valid;
    logic        pal;
    logic [7:0]  idx;
    logic [31:0] value;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    logic        done;
  } pix_t;

  // byte-lane palette write
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [1:0] lane;
    logic [7:0] data;
  } pal_wr_t;

  // sequencer status
  typedef struct packed {
    logic busy;
    logic final_issue;
  } iss_stat_t;

endpackage

/* sv/bmp_pixel_stream_decoder.sv */
// ---------------------------------------------------------------------------
// bmp_pixel_stream_decoder: BMP pixel array stream decoder
// Turns the byte stream after a BMP header (palette, then bottom-up pixel
// array) into pixels tagged with destination row and column.
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------
//   stream   | in        | stream_valid/stream_ready | stream_byte, frame_start
//   pixel    | out       | pixel_valid/pixel_ready   | pixel_value, dest_row,
//            |           |                           | dest_column, last_of_run,
//            |           |                           | frame_done
//   cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One byte per cycle, when the pixel side does not stall, in 8/16/24/32
// bpp and during palette load. A byte that yields several pixels (up to 8
// at 1 bpp, 2 at 4 bpp) holds the stream until its last pixel issues: the
// issue sequencer sends one pixel per cycle through the single palette
// read port. A byte's first pixel passes the job, palette read and output
// registers on its way to the pixel port. Any pixel-side stall freezes
// issue and read stages together; the stream keeps taking bytes while the
// job slot is free. rst is synchronous; it clears counters and pipeline
// valids, the palette memory is not cleared. cfg_ready is always high.
// ---------------------------------------------------------------------------
module bmp_pixel_stream_decoder #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        stream_valid,
  output logic        stream_ready,
  input  logic [7:0]  stream_byte,
  input  logic        frame_start,
  // pixels
  output logic        pixel_valid,
  input  logic        pixel_ready,
  output logic [31:0] pixel_value,
  output logic [11:0] dest_row,
  output logic [11:0] dest_column,
  output logic        last_of_run,
  output logic        frame_done,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [2:0]  pixel_mode;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [15:0] fill_mask;

  logic                 en;          // pipeline advance
  logic                 accept;
  logic                 job_push;
  logic                 job_free;
  bmpd_pkg::job_t       job;
  bmpd_pkg::pal_wr_t    pal_wr;
  bmpd_pkg::pix_t       req;
  bmpd_pkg::pix_t       res;
  bmpd_pkg::iss_stat_t  iss_stat;

  assign cfg_ready    = 1'b1;
  assign en           = !pixel_valid || pixel_ready;
  assign stream_ready = job_free;
  assign accept       = stream_valid && stream_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode   <= bmpd_pkg::RST_PIXEL_MODE;
      image_width  <= bmpd_pkg::RST_DIM;
      image_height <= bmpd_pkg::RST_DIM;
      fill_mask    <= bmpd_pkg::RST_FILL_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmpd_pkg::REG_PIXEL_MODE:   pixel_mode   <= cfg_data[2:0];
        bmpd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        bmpd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default:                    fill_mask    <= cfg_data;
      endcase
    end
  end

  // counters, palette load, direct-color assembly
  bmpd_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .stream_byte  (stream_byte),
    .frame_start  (frame_start),
    .pixel_mode   (pixel_mode),
    .image_width  (image_width),
    .image_height (image_height),
    .fill_mask    (fill_mask),
    .job          (job),
    .job_push     (job_push),
    .pal_wr       (pal_wr)
  );

  // one pixel per cycle out of the held job while en is high
  bmpd_issue u_issue (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .push   (job_push),
    .job_in (job),
    .req    (req),
    .stat   (iss_stat),
    .free   (job_free)
  );

  // palette lookup, registered read
  bmpd_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .wr  (pal_wr),
    .req (req),
    .res (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (en) begin
      pixel_valid <= res.valid;
      pixel_value <= res.value;
      dest_row    <= res.row;
      dest_column <= res.col;
      last_of_run <= res.last;
      frame_done  <= res.done;
    end
  end

`ifndef SYNTH
  // final pixel of the image always closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // a palette write must not overtake pending reads of a held job
  a_write_no_pending: assert property (@(posedge clk) disable iff (rst)
    pal_wr.en |-> !iss_stat.busy || iss_stat.final_issue)
    else $error("palette write while job reads pending");

  // an open run has its remaining pixels in flight
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !last_of_run |-> iss_stat.busy || res.valid)
    else $error("run left open with nothing in flight");

  // a new job is only taken when the slot is free
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !iss_stat.busy || iss_stat.final_issue)
    else $error("job overwritten before fully issued");
`endif

endmodule

/* sv/bmpd_front.sv */
// ---------------------------------------------------------------------------
// bmpd_front: byte decode and frame counters
// Tracks palette load, row bytes, columns and rows; assembles direct-color
// pixels and hands each pixel-producing byte to the issue sequencer.
// ---------------------------------------------------------------------------
module bmpd_front #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           stream_byte,
  input  logic                 frame_start,
  input  logic [2:0]           pixel_mode,
  input  logic [12:0]          image_width,
  input  logic [12:0]          image_height,
  input  logic [15:0]          fill_mask,
  output bmpd_pkg::job_t       job,
  output logic                 job_push,
  output bmpd_pkg::pal_wr_t    pal_wr
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = $clog2(MAX_WIDTH * 4 + 1);
  localparam int BW  = RBW + 3;

  logic [10:0]    pbc, pbc_e, pbc_next;
  logic [23:0]    pa, pa_e, pa_next;
  logic [1:0]     ac, ac_e, ac_next;
  logic [RBW-1:0] rbc, rbc_e, rbc_next, rbc_inc, row_bytes;
  logic [CW-1:0]  col, col_e, col_next, w_eff, room;
  logic [RW-1:0]  row, row_e, row_next, h_eff;
  logic [BW-1:0]  w_bits, row_bits, bits_sum;
  logic [10:0]    load_limit;
  logic [3:0]     n;
  logic [31:0]    value;
  logic           loading;

  always_comb begin
    pbc_e = frame_start ? '0 : pbc;
    pa_e  = frame_start ? '0 : pa;
    ac_e  = frame_start ? '0 : ac;
    rbc_e = frame_start ? '0 : rbc;
    col_e = frame_start ? '0 : col;
    row_e = frame_start ? '0 : row;

    // zero reads as one, oversize saturates
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end

    w_bits = BW'(w_eff);
    unique case (pixel_mode)
      bmpd_pkg::MODE_1BPP:  row_bits = w_bits;
      bmpd_pkg::MODE_4BPP:  row_bits = w_bits << 2;
      bmpd_pkg::MODE_8BPP:  row_bits = w_bits << 3;
      bmpd_pkg::MODE_16BPP: row_bits = w_bits << 4;
      bmpd_pkg::MODE_24BPP: row_bits = (w_bits << 4) + (w_bits << 3);
      default:              row_bits = w_bits << 5;
    endcase
    // round up to whole 32-bit words, in bytes
    bits_sum  = row_bits + BW'(31);
    row_bytes = RBW'(bits_sum >> 3) & ~RBW'(3);

    unique case (pixel_mode)
      bmpd_pkg::MODE_1BPP: load_limit = bmpd_pkg::LOAD_BYTES_1BPP;
      bmpd_pkg::MODE_4BPP: load_limit = bmpd_pkg::LOAD_BYTES_4BPP;
      bmpd_pkg::MODE_8BPP: load_limit = bmpd_pkg::LOAD_BYTES_8BPP;
      default:             load_limit = '0;
    endcase
    loading = (pixel_mode <= bmpd_pkg::MODE_8BPP) && (pbc_e < load_limit);

    pbc_next = pbc_e;
    pa_next  = pa_e;
    ac_next  = ac_e;
    rbc_next = rbc_e;
    col_next = col_e;
    row_next = row_e;
    room     = w_eff - col_e;
    rbc_inc  = rbc_e + RBW'(1);
    n        = '0;
    value    = '0;
    job      = '0;
    job_push = 1'b0;
    pal_wr   = '0;

    if (pixel_mode <= bmpd_pkg::MODE_32BPP) begin
      if (loading) begin
        pbc_next = pbc_e + 11'd1;
        // B,G,R land in lanes 2,1,0; the reserved byte is dropped
        pal_wr.en   = accept && (32'(pbc_e[10:2]) < 32'(PALETTE_DEPTH)) &&
                      (pbc_e[1:0] != 2'd3);
        pal_wr.addr = pbc_e[9:2];
        pal_wr.lane = 2'(2'd2 - pbc_e[1:0]);
        pal_wr.data = stream_byte;
      end else if (row_e < h_eff) begin
        if (col_e < w_eff) begin
          unique case (pixel_mode)
            bmpd_pkg::MODE_1BPP: begin
              n     = (32'(room) >= 32'd8) ? 4'd8 : 4'(room);
              value = {24'd0, stream_byte};
            end
            bmpd_pkg::MODE_4BPP: begin
              n     = (32'(room) >= 32'd2) ? 4'd2 : 4'(room);
              value = {24'd0, stream_byte};
            end
            bmpd_pkg::MODE_8BPP: begin
              n     = 4'd1;
              value = {24'd0, stream_byte};
            end
            bmpd_pkg::MODE_16BPP: begin
              if (ac_e == 2'd0) begin
                pa_next = {16'd0, stream_byte};
                ac_next = 2'd1;
              end else begin
                n       = 4'd1;
                value   = {16'd0, {stream_byte, pa_e[7:0]} | fill_mask};
                pa_next = '0;
                ac_next = '0;
              end
            end
            bmpd_pkg::MODE_24BPP: begin
              if (ac_e < 2'd2) begin
                pa_next = pa_e | (24'(stream_byte) << {ac_e, 3'b000});
                ac_next = ac_e + 2'd1;
              end else begin
                n       = 4'd1;
                value   = {8'd0, pa_e[23:16] | stream_byte, pa_e[15:0]};
                pa_next = '0;
                ac_next = '0;
              end
            end
            default: begin
              if (ac_e < 2'd3) begin
                pa_next = pa_e | (24'(stream_byte) << {ac_e, 3'b000});
                ac_next = ac_e + 2'd1;
              end else begin
                n       = 4'd1;
                value   = {stream_byte, pa_e};
                pa_next = '0;
                ac_next = '0;
              end
            end
          endcase
          col_next = col_e + CW'(n);
        end

        job.mode  = pixel_mode;
        job.value = value;
        job.cnt   = 3'(n - 4'd1);
        job.col   = 12'(col_e);
        job.row   = 12'(32'(h_eff) - 32'(row_e) - 32'd1);
        job.done  = (32'(col_e) + 32'(n) >= 32'(w_eff)) &&
                    (32'(row_e) + 32'd1 == 32'(h_eff));
        job_push  = accept && (n != '0);

        rbc_next = rbc_inc;
        if (rbc_inc >= row_bytes) begin
          rbc_next = '0;
          col_next = '0;
          pa_next  = '0;
          ac_next  = '0;
          row_next = row_e + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbc <= '0;
      pa  <= '0;
      ac  <= '0;
      rbc <= '0;
      col <= '0;
      row <= '0;
    end else if (accept) begin
      pbc <= pbc_next;
      pa  <= pa_next;
      ac  <= ac_next;
      rbc <= rbc_next;
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

/* sv/bmpd_issue.sv */
// ---------------------------------------------------------------------------
// bmpd_issue: pixel issue sequencer
// Holds one byte's job and issues its pixels one per cycle while en is
// high, with the palette index of each, toward the palette read stage.
// ---------------------------------------------------------------------------
module bmpd_issue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  push,
  input  bmpd_pkg::job_t        job_in,
  output bmpd_pkg::pix_t        req,
  output bmpd_pkg::iss_stat_t   stat,
  output logic                  free
);

  bmpd_pkg::job_t job;
  logic           job_valid;
  logic [2:0]     k;
  logic           last;
  logic [7:0]     b;

  assign last = (k == job.cnt);
  assign b    = job.value[7:0];

  assign stat.busy        = job_valid;
  assign stat.final_issue = job_valid && en && last;
  assign free             = !job_valid || (en && last);

  always_comb begin
    req       = '0;
    req.valid = job_valid;
    req.pal   = (job.mode <= bmpd_pkg::MODE_8BPP);
    req.value = job.value;
    req.col   = job.col + 12'(k);
    req.row   = job.row;
    req.last  = last;
    req.done  = job.done && last;
    // most significant bits first
    unique case (job.mode)
      bmpd_pkg::MODE_1BPP: req.idx = {7'd0, b[3'(3'd7 - k)]};
      bmpd_pkg::MODE_4BPP: req.idx = (k == 3'd0) ? {4'd0, b[7:4]} : {4'd0, b[3:0]};
      default:             req.idx = b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (en && job_valid) begin
        if (last) begin
          job_valid <= 1'b0;
        end else begin
          k <= k + 3'd1;
        end
      end
      if (push) begin
        job_valid <= 1'b1;
        job       <= job_in;
        k         <= '0;
      end
    end
  end

endmodule

/* sv/bmpd_palette.sv */
// ---------------------------------------------------------------------------
// bmpd_palette: palette memory and read stage
// One write port with byte lanes for the load phase, one registered read
// port for pixel lookup; indexes past the store read as zero.
// ---------------------------------------------------------------------------
module bmpd_palette #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bmpd_pkg::pal_wr_t  wr,
  input  bmpd_pkg::pix_t     req,
  output bmpd_pkg::pix_t     res
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0]    mem [PALETTE_DEPTH];
  logic [23:0]    rd_data;
  logic           rd_hit;
  bmpd_pkg::pix_t rd_meta;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      case (wr.lane)
        2'd0:    mem[wr.addr[AW-1:0]][7:0]   <= wr.data;
        2'd1:    mem[wr.addr[AW-1:0]][15:8]  <= wr.data;
        default: mem[wr.addr[AW-1:0]][23:16] <= wr.data;
      endcase
    end
    // read sees the old entry on a same-cycle write
    if (en && req.valid && req.pal) begin
      rd_data <= mem[req.idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_meta.valid <= 1'b0;
    end else if (en) begin
      rd_meta <= req;
      rd_hit  <= 32'(req.idx) < 32'(PALETTE_DEPTH);
    end
  end

  always_comb begin
    res = rd_meta;
    if (rd_meta.pal) begin
      res.value = rd_hit ? {8'd0, rd_data} : 32'd0;
    end
  end

endmodule
